[hdl/qbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbf_pkg
// Shared widths and the sequencer state type of the Bezier flight step.
// ----------------------------------------------------------------------------
package qbf_pkg;

  localparam int CNT_W   = 12;  // step counts
  localparam int CRD_W   = 19;  // coordinate fields at the ports
  localparam int POS_W   = 20;  // curve point fields
  localparam int ROLL_W  = 21;  // roll vector fields
  localparam int ACC_W   = 32;  // wrapping arithmetic width
  localparam int N_AXES  = 3;
  localparam int N_TERMS = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_SQR,
    ST_WGT,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_OUT
  } qbf_state_t;

endpackage

[hdl/qbf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qbf_div #(
  parameter int DVD_W = 24,
  parameter int DSR_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    quo_r, quo_nxt;
  logic [DSR_W-1:0]    rem_r, rem_nxt;
  logic [DSR_W-1:0]    dsr_r, dsr_nxt;
  logic [DSR_W+1:0]    rem_sh;
  logic [DSR_W+1:0]    diff;

  assign rem_sh = {1'b0, rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // restore on borrow, else keep the difference
      if (diff[DSR_W+1]) begin
        rem_nxt = rem_sh[DSR_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DSR_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/quadratic_bezier_flight_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_flight_step
// One step of a 3-D quadratic Bezier flight: curve point, step count and
// the roll vector on the final step.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high until it has
// finished it. While in_stall is high the item passes through the bit-serial
// fraction divider, then the fraction is squared and the weights are formed,
// then each of the three axes is worked on the single shared 32x32
// multiplier and accumulator, and then the output register is loaded. The
// output register holds off the last step while an earlier result is still
// stalled, and a new item is taken only once the block is back in idle. The
// result waits in that register while the next item is already being taken.
// The last emitted point is kept for the roll vector and is zero after reset.
// The curve arithmetic wraps at 32 bits.
module quadratic_bezier_flight_step
  import qbf_pkg::*;
#(
  parameter int FRAC_BITS  = 12,
  parameter int COORD_BITS = 19
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CNT_W-1:0]         in_steps_left,
  input  logic [CNT_W-1:0]         in_steps_total,
  input  logic signed [CRD_W-1:0]  in_start_x,
  input  logic signed [CRD_W-1:0]  in_start_y,
  input  logic signed [CRD_W-1:0]  in_start_z,
  input  logic signed [CRD_W-1:0]  in_ctrl_x,
  input  logic signed [CRD_W-1:0]  in_ctrl_y,
  input  logic signed [CRD_W-1:0]  in_ctrl_z,
  input  logic signed [CRD_W-1:0]  in_end_x,
  input  logic signed [CRD_W-1:0]  in_end_y,
  input  logic signed [CRD_W-1:0]  in_end_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic signed [POS_W-1:0]  out_pos_z,
  output logic [CNT_W-1:0]         out_steps_after,
  output logic                     out_landed,
  output logic signed [ROLL_W-1:0] out_roll_dx,
  output logic signed [ROLL_W-1:0] out_roll_dy,
  output logic signed [ROLL_W-1:0] out_roll_dz
);

  localparam int DVD_W = CNT_W + FRAC_BITS;
  localparam logic [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_BITS;

  // signed divide by ONE_FX, truncating toward zero
  function automatic logic [ACC_W-1:0] trunc_frac(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] b;
    b = v + (v[ACC_W-1] ? (ONE_FX - ACC_W'(1)) : '0);
    return ACC_W'($signed(b) >>> FRAC_BITS);
  endfunction

  qbf_state_t state_r, state_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;
  logic [CNT_W-1:0]      div_dsr;

  logic [CNT_W-1:0]      left_r;
  logic [COORD_BITS-1:0] coord_r [N_TERMS][N_AXES];
  logic [ACC_W-1:0]      q_r;
  logic [ACC_W-1:0]      prod_r;
  logic [ACC_W-1:0]      sq_r;
  logic [ACC_W-1:0]      w_r [N_TERMS];
  logic [ACC_W-1:0]      acc_r;
  logic [1:0]            t_r;
  logic [1:0]            a_r;
  logic [POS_W-1:0]      pos_r [N_AXES];
  logic [POS_W-1:0]      prev_r [N_AXES];

  logic [ACC_W-1:0]      mul_a, mul_b;
  logic [ACC_W-1:0]      mul_p;
  logic [ACC_W-1:0]      two_q;
  logic [ACC_W-1:0]      rnd;

  // sequencer strobes
  logic ld_q, ld_prod, ld_sq, ld_w, ld_acc, ld_pos, ld_out;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign div_dsr = (in_steps_total == '0) ? CNT_W'(1) : in_steps_total;

  qbf_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend ({in_steps_left, {FRAC_BITS{1'b0}}}),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_WGT;
      ST_WGT:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (t_r == 2'd2) ? ST_RND : ST_MUL;
      ST_RND:  state_nxt = (a_r == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ld_q    = 1'b0;
    ld_prod = 1'b0;
    ld_sq   = 1'b0;
    ld_w    = 1'b0;
    ld_acc  = 1'b0;
    ld_pos  = 1'b0;
    ld_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_DIV:  ld_q = div_done;
      ST_SQ:   ld_prod = 1'b1;
      ST_SQR:  ld_sq = 1'b1;
      ST_WGT:  ld_w = 1'b1;
      ST_MUL:  ld_prod = 1'b1;
      ST_ACC:  ld_acc = 1'b1;
      ST_RND:  ld_pos = 1'b1;
      ST_OUT:  ld_out = out_free;
      default: ;
    endcase
  end

  // shared multiplier: q*q while squaring, weight*coordinate otherwise
  always_comb begin
    if (state_r == ST_SQ) begin
      mul_a = q_r;
      mul_b = q_r;
    end else begin
      mul_a = w_r[t_r];
      mul_b = ACC_W'($signed(coord_r[t_r][a_r]));
    end
  end

  assign mul_p = mul_a * mul_b;
  assign two_q = {q_r[ACC_W-2:0], 1'b0};
  assign rnd   = trunc_frac(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r        <= in_steps_left;
      coord_r[0][0] <= in_start_x[COORD_BITS-1:0];
      coord_r[0][1] <= in_start_y[COORD_BITS-1:0];
      coord_r[0][2] <= in_start_z[COORD_BITS-1:0];
      coord_r[1][0] <= in_ctrl_x[COORD_BITS-1:0];
      coord_r[1][1] <= in_ctrl_y[COORD_BITS-1:0];
      coord_r[1][2] <= in_ctrl_z[COORD_BITS-1:0];
      coord_r[2][0] <= in_end_x[COORD_BITS-1:0];
      coord_r[2][1] <= in_end_y[COORD_BITS-1:0];
      coord_r[2][2] <= in_end_z[COORD_BITS-1:0];
    end
    if (ld_q) begin
      q_r <= ONE_FX - ACC_W'(div_quo);
    end
    if (ld_prod) begin
      prod_r <= mul_p;
    end
    if (ld_sq) begin
      sq_r <= trunc_frac(prod_r);
    end
    if (ld_w) begin
      w_r[0] <= ONE_FX - two_q + sq_r;
      w_r[1] <= two_q - {sq_r[ACC_W-2:0], 1'b0};
      w_r[2] <= sq_r;
    end
    if (ld_pos) begin
      pos_r[a_r] <= rnd[POS_W-1:0];
    end
  end

  // term and axis counters, accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r   <= '0;
      a_r   <= '0;
      acc_r <= '0;
    end else if (ld_w) begin
      t_r   <= '0;
      a_r   <= '0;
      acc_r <= '0;
    end else if (ld_acc) begin
      acc_r <= acc_r + prod_r;
      if (t_r != 2'd2) begin
        t_r <= t_r + 2'd1;
      end
    end else if (ld_pos) begin
      acc_r <= '0;
      t_r   <= '0;
      a_r   <= a_r + 2'd1;
    end
  end

  // output register and stored point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      prev_r[2] <= '0;
    end else begin
      if (ld_out) begin
        out_valid <= 1'b1;
        prev_r[0] <= pos_r[0];
        prev_r[1] <= pos_r[1];
        prev_r[2] <= pos_r[2];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_pos_x  <= pos_r[0];
      out_pos_y  <= pos_r[1];
      out_pos_z  <= pos_r[2];
      out_landed <= (left_r == '0);
      if (left_r == '0) begin
        out_steps_after <= '0;
        out_roll_dx <= {pos_r[0][POS_W-1], pos_r[0]} - {prev_r[0][POS_W-1], prev_r[0]};
        out_roll_dy <= {pos_r[1][POS_W-1], pos_r[1]} - {prev_r[1][POS_W-1], prev_r[1]};
        out_roll_dz <= {pos_r[2][POS_W-1], pos_r[2]} - {prev_r[2][POS_W-1], prev_r[2]};
      end else begin
        out_steps_after <= left_r - CNT_W'(1);
        out_roll_dx     <= '0;
        out_roll_dy     <= '0;
        out_roll_dz     <= '0;
      end
    end
  end

endmodule

[tb/quadratic_bezier_flight_step_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_flight_step_tb
// Self-checking bench for the Bezier flight step. A bit-accurate predictor
// computes each curve point, step count and roll vector as items are taken.
// Every result is compared against those predictions in order. Directed
// items cover the extremes, zero and overrun counts, and points that wrap.
// Random flights count down to landing, some stopping short, with noise
// items mixed in and random idling on both channels.
// ----------------------------------------------------------------------------
module quadratic_bezier_flight_step_tb;
  import qbf_pkg::*;

  localparam int FRAC           = 12;
  localparam int ONE            = 1 << FRAC;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LATENCY        = 64;

  typedef logic signed [CRD_W-1:0] coord_t;

  localparam coord_t CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam coord_t CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  typedef struct {
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] total;
    coord_t           start_pt [N_AXES];
    coord_t           ctrl_pt  [N_AXES];
    coord_t           end_pt   [N_AXES];
  } flight_item_t;

  typedef struct {
    logic signed [POS_W-1:0]  pos [N_AXES];
    logic [CNT_W-1:0]         steps_after;
    logic                     landed;
    logic signed [ROLL_W-1:0] roll [N_AXES];
  } flight_point_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CNT_W-1:0] in_steps_left;
  logic [CNT_W-1:0] in_steps_total;
  coord_t in_start_x, in_start_y, in_start_z;
  coord_t in_ctrl_x, in_ctrl_y, in_ctrl_z;
  coord_t in_end_x, in_end_y, in_end_z;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [CNT_W-1:0] out_steps_after;
  logic out_landed;
  logic signed [ROLL_W-1:0] out_roll_dx, out_roll_dy, out_roll_dz;

  flight_point_t           pending_points [$];
  logic signed [POS_W-1:0] last_pos [N_AXES] = '{default: '0};
  string                   axis_name [N_AXES] = '{"x", "y", "z"};
  int                      error_count = 0;
  int                      idle_cycles = 0;
  int                      hold_cnt = 0;
  bit                      quiet = 1'b0;

  quadratic_bezier_flight_step #(
    .FRAC_BITS(FRAC),
    .COORD_BITS(CRD_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_steps_left(in_steps_left),
    .in_steps_total(in_steps_total),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_start_z(in_start_z),
    .in_ctrl_x(in_ctrl_x),
    .in_ctrl_y(in_ctrl_y),
    .in_ctrl_z(in_ctrl_z),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .in_end_z(in_end_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z),
    .out_steps_after(out_steps_after),
    .out_landed(out_landed),
    .out_roll_dx(out_roll_dx),
    .out_roll_dy(out_roll_dy),
    .out_roll_dz(out_roll_dz)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Signed divide by ONE, truncating toward zero.
  function automatic logic [ACC_W-1:0] frac_trunc(logic [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v;
    if (s[ACC_W-1]) s = s + (ONE - 1);
    return s >>> FRAC;
  endfunction

  function automatic logic [ACC_W-1:0] widen(coord_t c);
    logic signed [ACC_W-1:0] s;
    s = c;
    return s;
  endfunction

  // Curve point for one item; updates the stored last point.
  function automatic flight_point_t curve_point(flight_item_t it);
    flight_point_t r;
    logic [ACC_W-1:0] tot, q, sq, two_q, w0, w1, w2, acc, scaled;
    tot    = (it.total == '0) ? 1 : it.total;
    q      = ONE - ((ACC_W'(it.left) << FRAC) / tot);
    sq     = frac_trunc(q * q);
    two_q  = q << 1;
    w0     = ONE - two_q + sq;
    w1     = two_q - (sq << 1);
    w2     = sq;
    for (int a = 0; a < N_AXES; a++) begin
      acc = w0 * widen(it.start_pt[a]) + w1 * widen(it.ctrl_pt[a])
          + w2 * widen(it.end_pt[a]);
      scaled = frac_trunc(acc);
      r.pos[a] = scaled[POS_W-1:0];
      // both points sign-extend to the roll width
      if (it.left == '0) r.roll[a] = r.pos[a] - last_pos[a];
      else r.roll[a] = '0;
      last_pos[a] = r.pos[a];
    end
    r.landed      = (it.left == '0);
    r.steps_after = (it.left == '0) ? '0 : it.left - 1'b1;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return CRD_MAX;
      1:       return CRD_MIN;
      2:       return coord_t'(int'($urandom_range(0, 15)) - 8);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic flight_item_t random_item(int left, int total);
    flight_item_t it;
    it.left  = CNT_W'(left);
    it.total = CNT_W'(total);
    for (int a = 0; a < N_AXES; a++) begin
      it.start_pt[a] = rand_coord();
      it.ctrl_pt[a]  = rand_coord();
      it.end_pt[a]   = rand_coord();
    end
    return it;
  endfunction

  function automatic flight_item_t uniform_item(int left, int total, coord_t s,
                                                coord_t c, coord_t e);
    flight_item_t it;
    it.left  = CNT_W'(left);
    it.total = CNT_W'(total);
    for (int a = 0; a < N_AXES; a++) begin
      it.start_pt[a] = s;
      it.ctrl_pt[a]  = c;
      it.end_pt[a]   = e;
    end
    return it;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Send one item; valid stays high afterwards until the next gap or drain.
  task automatic send_item(flight_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_steps_left  <= it.left;
    in_steps_total <= it.total;
    in_start_x     <= it.start_pt[0];
    in_start_y     <= it.start_pt[1];
    in_start_z     <= it.start_pt[2];
    in_ctrl_x      <= it.ctrl_pt[0];
    in_ctrl_y      <= it.ctrl_pt[1];
    in_ctrl_z      <= it.ctrl_pt[2];
    in_end_x       <= it.end_pt[0];
    in_end_y       <= it.end_pt[1];
    in_end_z       <= it.end_pt[2];
    do @(posedge clk); while (in_stall);
    pending_points.push_back(curve_point(it));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic test_curve_extremes();
    flight_item_t it;
    send_item(uniform_item(0, 1, CRD_MAX, CRD_MAX, CRD_MAX));
    send_item(uniform_item(0, 1, CRD_MIN, CRD_MIN, CRD_MIN));
    send_item(uniform_item(4095, 4095, CRD_MAX, CRD_MIN, CRD_MAX));
    send_item(uniform_item(1, 2, CRD_MIN, CRD_MAX, CRD_MIN));
    send_item(uniform_item(2048, 4095, CRD_MAX, CRD_MAX, CRD_MIN));
    // small negative coordinates where truncation toward zero shows
    it = random_item(2, 3);
    for (int a = 0; a < N_AXES; a++) begin
      it.start_pt[a] = coord_t'(-1 - a);
      it.ctrl_pt[a]  = coord_t'(-5 - a);
      it.end_pt[a]   = coord_t'(-7 + a);
    end
    send_item(it);
    send_item(random_item(0, 4095));
  endtask

  task automatic test_zero_total();
    send_item(random_item(0, 0));
    send_item(random_item(5, 0));
    send_item(random_item(4095, 0));
  endtask

  task automatic test_count_above_total();
    send_item(uniform_item(4095, 1, CRD_MAX, CRD_MAX, CRD_MAX));
    send_item(random_item(4095, 4094));
    // weights far outside one push the point past 20 bits
    send_item(uniform_item(3, 1, CRD_MIN, CRD_MAX, CRD_MIN));
    send_item(random_item(2, 1));
  endtask

  task automatic test_landing_sequence();
    flight_item_t it;
    it = random_item(3, 4);
    for (int k = 3; k >= 0; k--) begin
      it.left = CNT_W'(k);
      send_item(it);
    end
    send_item(random_item(0, 4));
    send_item(random_item(0, 17));
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) send_item(random_item($urandom_range(0, 4), 5));
    hold_until_drained();
  endtask

  task automatic test_random_flights(int n_items);
    int sent, len, total, stop_at;
    flight_item_t it;
    sent = 0;
    while (sent < n_items) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) == 0) begin
        // noise: any count, any total, zero total included
        total = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 4095);
        send_item(random_item($urandom_range(0, 4095), total));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       total = len;
          1:       total = $urandom_range(len, 64);
          2:       total = $urandom_range(len, 4095);
          default: total = 4095;
        endcase
        // broken flights stop short of landing
        stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : 0;
        it = random_item(len - 1, total);
        for (int k = len - 1; k >= stop_at; k--) begin
          it.left = CNT_W'(k);
          send_item(it);
          sent++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Result stall: held for a drawn number of cycles of each result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) hold_cnt = quiet ? 0 : $urandom_range(0, 13);
    else if (out_valid && hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt != 0);
  end

  always @(posedge clk) begin
    flight_point_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.pos[0]      = out_pos_x;
      got.pos[1]      = out_pos_y;
      got.pos[2]      = out_pos_z;
      got.roll[0]     = out_roll_dx;
      got.roll[1]     = out_roll_dy;
      got.roll[2]     = out_roll_dz;
      got.steps_after = out_steps_after;
      got.landed      = out_landed;
      if (pending_points.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        want = pending_points.pop_front();
        for (int a = 0; a < N_AXES; a++) begin
          if (got.pos[a] !== want.pos[a])
            report_error($sformatf("pos_%s got %0d expected %0d", axis_name[a],
                                   got.pos[a], want.pos[a]));
          if (got.roll[a] !== want.roll[a])
            report_error($sformatf("roll_d%s got %0d expected %0d", axis_name[a],
                                   got.roll[a], want.roll[a]));
        end
        if (got.steps_after !== want.steps_after)
          report_error($sformatf("steps_after got %0d expected %0d",
                                 got.steps_after, want.steps_after));
        if (got.landed !== want.landed)
          report_error($sformatf("landed got %b expected %b", got.landed, want.landed));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("quadratic_bezier_flight_step regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_steps_left  <= '0;
    in_steps_total <= '0;
    in_start_x     <= '0;
    in_start_y     <= '0;
    in_start_z     <= '0;
    in_ctrl_x      <= '0;
    in_ctrl_y      <= '0;
    in_ctrl_z      <= '0;
    in_end_x       <= '0;
    in_end_y       <= '0;
    in_end_z       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_curve_extremes();
    test_zero_total();
    test_count_above_total();
    test_landing_sequence();
    test_drain_pause();
    test_random_flights(830);
    hold_until_drained();
    repeat (LATENCY) @(posedge clk);
    if (pending_points.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_points.size()));
    if (error_count == 0) begin
      $display("quadratic_bezier_flight_step regression: pass");
    end else begin
      $display("quadratic_bezier_flight_step regression: fail");
    end
    $finish;
  end

endmodule
